// ===== rtl/dipa_pkg.sv =====
// ----------------------------------------------------------------------------
// dipa_pkg
// Types and character codes shared by the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
package dipa_pkg;

  localparam int CHAR_W = 8;
  localparam int ADDR_W = 32;
  localparam int BYTE_W = 8;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_SKIP   = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  // Parser state. Only the low byte of each closed part is ever packed,
  // so the stored parts keep just that byte.
  typedef struct packed {
    phase_t            phase;
    base_t             base;
    logic [ADDR_W-1:0] acc;
    logic [1:0]        parts;
    logic [BYTE_W-1:0] part0;
    logic [BYTE_W-1:0] part1;
    logic [BYTE_W-1:0] part2;
  } parse_state_t;

  // Result produced by one character.
  typedef struct packed {
    logic              emit;
    logic [ADDR_W-1:0] address;
    logic              malformed;
  } parse_result_t;

endpackage

// ===== rtl/dipa_step.sv =====
// ----------------------------------------------------------------------------
// dipa_step
// Next-state and result logic for one character of the address string.
// ----------------------------------------------------------------------------
module dipa_step
  import dipa_pkg::*;
(
  input  parse_state_t        st,
  input  logic [CHAR_W-1:0]   ch,
  output parse_state_t        st_nxt,
  output parse_result_t       res
);

  logic              is_dec;
  logic              is_lc_hex;
  logic              is_uc_hex;
  logic              is_space;
  logic              is_digit;
  logic [3:0]        digit;
  base_t             eff_base;
  logic [ADDR_W-1:0] scaled;
  logic [ADDR_W-1:0] packed_addr;
  logic              bad_end;

  always_comb begin
    is_dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_lc_hex = (ch >= CH_LC_A) && (ch <= CH_LC_F);
    is_uc_hex = (ch >= CH_UC_A) && (ch <= CH_UC_F);
    is_space  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  end

  // Base in force for this character: a part opens in decimal, a leading
  // zero switches it to octal, and "0x" has already set hex.
  always_comb begin
    unique case (st.phase)
      PH_START: eff_base = BASE_DEC;
      PH_ZERO:  eff_base = BASE_OCT;
      default:  eff_base = st.base;
    endcase
  end

  always_comb begin
    is_digit = is_dec || ((eff_base == BASE_HEX) && (is_lc_hex || is_uc_hex));
    if (is_dec) begin
      digit = 4'(ch - CH_ZERO);
    end else if (is_lc_hex) begin
      digit = 4'(ch - CH_LC_A + 8'd10);
    end else begin
      digit = 4'(ch - CH_UC_A + 8'd10);
    end
    unique case (eff_base)
      BASE_HEX: scaled = {st.acc[ADDR_W-5:0], 4'b0};
      BASE_OCT: scaled = {st.acc[ADDR_W-4:0], 3'b0};
      default:  scaled = {st.acc[ADDR_W-4:0], 3'b0} + {st.acc[ADDR_W-2:0], 1'b0};
    endcase
  end

  always_comb begin
    unique case (st.parts)
      2'd0: packed_addr = st.acc;
      2'd1: packed_addr = {st.part0, st.acc[23:0]};
      2'd2: packed_addr = {st.part0, st.part1, st.acc[15:0]};
      default: packed_addr = {st.part0, st.part1, st.part2, st.acc[7:0]};
    endcase
    bad_end = !((st.phase == PH_START) || (st.phase == PH_ZERO) ||
                (st.phase == PH_DIGITS) || (st.phase == PH_SKIP));
  end

  always_comb begin
    st_nxt        = st;
    res.emit      = 1'b0;
    res.address   = bad_end ? {ADDR_W{1'b1}} : packed_addr;
    res.malformed = bad_end;

    if (ch == CH_NUL) begin
      // End of string: report and return to the reset state. The stored
      // parts are left alone; they are rewritten before they are read.
      res.emit     = 1'b1;
      st_nxt.phase = PH_START;
      st_nxt.base  = BASE_DEC;
      st_nxt.acc   = '0;
      st_nxt.parts = 2'd0;
    end else if ((st.phase == PH_START) && (ch == CH_ZERO)) begin
      st_nxt.base  = BASE_OCT;
      st_nxt.phase = PH_ZERO;
    end else if ((st.phase == PH_ZERO) && ((ch == CH_LC_X) || (ch == CH_UC_X))) begin
      st_nxt.base  = BASE_HEX;
      st_nxt.phase = PH_DIGITS;
    end else if ((st.phase == PH_START) || (st.phase == PH_ZERO) ||
                 (st.phase == PH_DIGITS)) begin
      st_nxt.base = eff_base;
      if (is_digit) begin
        st_nxt.acc   = scaled + ADDR_W'(digit);
        st_nxt.phase = PH_DIGITS;
      end else if (ch == CH_DOT) begin
        if (st.parts == 2'd3) begin
          st_nxt.phase = PH_ERROR;
        end else begin
          unique case (st.parts)
            2'd0:    st_nxt.part0 = st.acc[BYTE_W-1:0];
            2'd1:    st_nxt.part1 = st.acc[BYTE_W-1:0];
            default: st_nxt.part2 = st.acc[BYTE_W-1:0];
          endcase
          st_nxt.parts = st.parts + 2'd1;
          st_nxt.acc   = '0;
          st_nxt.base  = BASE_DEC;
          st_nxt.phase = PH_START;
        end
      end else if (is_space) begin
        st_nxt.phase = PH_SKIP;
      end else begin
        st_nxt.phase = PH_ERROR;
      end
    end else if (st.phase != PH_SKIP) begin
      // Error phase and unused codes both settle in the error phase.
      st_nxt.phase = PH_ERROR;
    end
  end

endmodule

// ===== rtl/dotted_ipv4_address_parser.sv =====
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser
// Streaming parser of dotted-quad IPv4 address strings, one character a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// The input channel carries one ASCII character per request on in_tdata; a
// zero byte ends the string. Parts are decimal, octal after a leading zero,
// or hex after "0x"/"0X", and are packed as a, a.b, a.b.c or a.b.c.d with
// the first part in the top byte. Only the terminator produces a request on
// the output channel: out_tdata holds the address in host order and
// out_tuser flags a malformed string, in which case the address is all ones.
//
// Throughput is one character per cycle while the output is not stalled: the
// character register feeds the per-character decode and accumulator update
// (a shift-add on 32 bits), and the result lands in the output register in
// the same step. Once the terminator is in the character register, out_tvalid
// rises when it moves on into the output register; a stall can hold it there.
//
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a new string. When the receiver stalls, the result
// waits in the output register; the character register still takes one more
// character, after which in_tready drops until out_tready frees the slot.
// ----------------------------------------------------------------------------
module dotted_ipv4_address_parser
  import dipa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Input channel. in_tdata: character [7:0].
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  // Output channel. out_tdata: address [31:0]. out_tuser: malformed [0].
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ADDR_W-1:0] out_tdata,
  output logic [0:0]        out_tuser
);

  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_bad_r;
  parse_state_t      st_r;
  parse_state_t      st_nxt;
  parse_result_t     res;
  logic              advance;

  // The held character moves on whenever the output slot is free or is
  // being emptied in this cycle; characters without a result never wait
  // on anything else, but keeping one rule keeps the order simple.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  dipa_step u_step (
    .st     (st_r),
    .ch     (in_char_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // The stored parts are rewritten before they are read, so they take no
  // reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.phase  <= PH_START;
      st_r.base   <= BASE_DEC;
      st_r.acc    <= '0;
      st_r.parts  <= 2'd0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        st_r.phase  <= st_nxt.phase;
        st_r.base   <= st_nxt.base;
        st_r.acc    <= st_nxt.acc;
        st_r.parts  <= st_nxt.parts;
        st_r.part0  <= st_nxt.part0;
        st_r.part1  <= st_nxt.part1;
        st_r.part2  <= st_nxt.part2;
        out_valid_r <= res.emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
    if (advance && res.emit) begin
      out_addr_r <= res.address;
      out_bad_r  <= res.malformed;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_addr_r;
  assign out_tuser[0] = out_bad_r;

endmodule
